### src/qsde_pkg.sv
// Shared constants and types for the pairwise swap delta engine.
// No dependencies; imported by the top level and by the checker.
package qsde_pkg;

    localparam int MAX_N     = 64;
    localparam int IDX_W     = $clog2(MAX_N);
    localparam int N_W       = IDX_W + 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MAT_DEPTH = MAX_N * MAX_N;
    localparam int ENTRY_W   = 16;
    localparam int DIFF_W    = ENTRY_W + 1;
    localparam int PROD_W    = 2 * ENTRY_W;
    localparam int DELTA_W   = 46;
    localparam int COST_W    = 44;
    localparam int CFG_W     = 7;
    localparam int OP_W      = 3;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 160;

    localparam logic [DELTA_W-1:0] DESCENT_LIMIT = DELTA_W'(999999999);

    typedef enum logic [OP_W-1:0] {
        OP_WR_FLOW = 3'd0,
        OP_WR_DIST = 3'd1,
        OP_WR_PERM = 3'd2,
        OP_INIT    = 3'd3,
        OP_SWAP    = 3'd4,
        OP_STEP    = 3'd5,
        OP_READ    = 3'd6
    } opcode_t;

endpackage

### src/qsde_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qsde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/qap_swap_delta_engine.sv
// Top level of the quadratic assignment swap delta engine: sequencer,
// arithmetic and five RAMs. Depends on qsde_pkg and qsde_ram.
//
//  channel   | signals                         | contents
//  ----------+---------------------------------+----------------------------------
//  input     | s_axis_tvalid/tready/tdata/tuser| one command beat
//  result    | m_axis_tvalid/tready/tdata      | one result beat per command
//  config    | cfg_wr_en/cfg_wr_data           | problem size n
//
// Init forms the cost from one product per matrix cell, then the delta table
// from a full delta per pair; a swap, or a descent step that makes a move,
// repeats that full table pass, bounded by one read port per RAM in the loop.
// Reset is synchronous and active low; the RAMs need no clearing pass.
// A new command is taken while the previous result still waits on m_axis.
module qap_swap_delta_engine
    import qsde_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // row_index[5:0], col_index[11:6], entry_value[27:12], zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    // opcode[2:0]
    input  logic [OP_W-1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // cost_now[43:0], cost_best[87:44], first_pos[93:88], second_pos[99:94],
    // move_cost[145:100], moved[146], perm_entry[152:147], best_entry[158:153],
    // rejected[159]
    output logic [OUT_W-1:0] m_axis_tdata
);

    typedef enum logic [27:0] {
        ST_IDLE    = 28'h0000001,
        ST_EXEC    = 28'h0000002,
        ST_RD_WAIT = 28'h0000004,
        ST_CI_RD   = 28'h0000008,
        ST_CI_CAP  = 28'h0000010,
        ST_CJ_CAP  = 28'h0000020,
        ST_CV_MUL  = 28'h0000040,
        ST_CV_ACC  = 28'h0000080,
        ST_PR_I    = 28'h0000100,
        ST_PR_J    = 28'h0000200,
        ST_PR_JC   = 28'h0000400,
        ST_TA      = 28'h0000800,
        ST_TB      = 28'h0001000,
        ST_TC      = 28'h0002000,
        ST_TD      = 28'h0004000,
        ST_K_RD    = 28'h0008000,
        ST_K_CAP   = 28'h0010000,
        ST_PAIR_WR = 28'h0020000,
        ST_BC_RD   = 28'h0040000,
        ST_BC_WR   = 28'h0080000,
        ST_SW_RD   = 28'h0100000,
        ST_SW_CAP1 = 28'h0200000,
        ST_SW_CAP2 = 28'h0400000,
        ST_SW_WR2  = 28'h0800000,
        ST_DS_RD   = 28'h1000000,
        ST_DS_CAP  = 28'h2000000,
        ST_DS_END  = 28'h4000000,
        ST_FINISH  = 28'h8000000
    } state_t;

    // Which of the four product terms of a pair delta is being formed.
    typedef enum logic [1:0] {
        TERM_DIAG  = 2'd0,
        TERM_CROSS = 2'd1,
        TERM_COL   = 2'd2,
        TERM_ROW   = 2'd3
    } term_t;

    state_t                     state_reg;
    term_t                      sel_reg;
    opcode_t                    op_reg;
    logic [IDX_W-1:0]           row_reg, col_reg;
    logic [ENTRY_W-1:0]         val_reg;
    logic [CFG_W-1:0]           size_reg;
    logic                       init_reg;
    logic [COST_W-1:0]          running_reg, lowest_reg;
    logic [IDX_W-1:0]           i_reg, j_reg, k_reg, r_reg, s_reg;
    logic [IDX_W-1:0]           pi_reg, pj_reg, pk_reg;
    logic [ENTRY_W-1:0]         fa_reg, dc_reg;
    logic signed [DIFF_W-1:0]   da_reg, db_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [DELTA_W-1:0]         acc_reg;
    logic signed [DELTA_W-1:0]  ds_best_reg;
    logic [IDX_W-1:0]           ds_bi_reg, ds_bj_reg;
    logic                       ds_found_reg;
    logic [IDX_W-1:0]           res_first_reg, res_second_reg, res_pe_reg, res_be_reg;
    logic [DELTA_W-1:0]         res_mcost_reg;
    logic                       res_moved_reg, res_rej_reg;
    logic                       m_valid_reg;
    logic [OUT_W-1:0]           m_data_reg;

    logic [N_W-1:0]             n_eff;
    logic                       bad_mat, bad_perm, bad_swap, bad_read, read_pair_ok;
    logic                       j_last, pair_last, k_last, k_skip;
    logic [COST_W-1:0]          cost_sum;
    logic signed [2*DIFF_W-1:0] term_prod;

    logic                       f_wr_en, d_wr_en, p_wr_en, b_wr_en, t_wr_en;
    logic [ADDR_W-1:0]          f_rd_addr, d_rd_addr, t_rd_addr, t_wr_addr;
    logic [ADDR_W-1:0]          mat_wr_addr, fa_addr, fb_addr, dc_addr, dd_addr;
    logic [IDX_W-1:0]           p_rd_addr, p_wr_addr, p_wr_data, b_rd_addr;
    logic [ENTRY_W-1:0]         f_rd_data, d_rd_data;
    logic [IDX_W-1:0]           p_rd_data, b_rd_data;
    logic [DELTA_W-1:0]         t_rd_data;

    always_comb begin
        n_eff = size_reg;
        if (size_reg < CFG_W'(2)) begin
            n_eff = N_W'(2);
        end else if (size_reg > CFG_W'(MAX_N)) begin
            n_eff = N_W'(MAX_N);
        end
    end

    assign bad_mat  = ({1'b0, row_reg} >= n_eff) || ({1'b0, col_reg} >= n_eff);
    assign bad_perm = ({1'b0, row_reg} >= n_eff) || (val_reg >= ENTRY_W'(n_eff));
    assign bad_swap = !init_reg || (row_reg >= col_reg) || ({1'b0, col_reg} >= n_eff);
    assign bad_read = ({1'b0, row_reg} >= n_eff);
    assign read_pair_ok = (row_reg < col_reg) && ({1'b0, col_reg} < n_eff);

    assign j_last    = (({1'b0, j_reg} + N_W'(1)) == n_eff);
    assign pair_last = j_last && (({1'b0, i_reg} + N_W'(2)) == n_eff);
    assign k_last    = (({1'b0, k_reg} + N_W'(1)) == n_eff);
    assign k_skip    = (k_reg == i_reg) || (k_reg == j_reg);
    assign cost_sum  = running_reg + COST_W'(prod_reg);
    assign term_prod = da_reg * db_reg;
    assign mat_wr_addr = {row_reg, col_reg};

    // Flow and distance addresses of the two reads for the current term.
    always_comb begin
        unique case (sel_reg)
            TERM_DIAG: begin
                fa_addr = {i_reg, i_reg};  fb_addr = {j_reg, j_reg};
                dc_addr = {pj_reg, pj_reg}; dd_addr = {pi_reg, pi_reg};
            end
            TERM_CROSS: begin
                fa_addr = {i_reg, j_reg};  fb_addr = {j_reg, i_reg};
                dc_addr = {pj_reg, pi_reg}; dd_addr = {pi_reg, pj_reg};
            end
            TERM_COL: begin
                fa_addr = {k_reg, i_reg};  fb_addr = {k_reg, j_reg};
                dc_addr = {pk_reg, pj_reg}; dd_addr = {pk_reg, pi_reg};
            end
            TERM_ROW: begin
                fa_addr = {i_reg, k_reg};  fb_addr = {j_reg, k_reg};
                dc_addr = {pj_reg, pk_reg}; dd_addr = {pi_reg, pk_reg};
            end
            default: begin
                fa_addr = '0; fb_addr = '0; dc_addr = '0; dd_addr = '0;
            end
        endcase
    end

    always_comb begin
        f_wr_en   = 1'b0;
        d_wr_en   = 1'b0;
        p_wr_en   = 1'b0;
        b_wr_en   = 1'b0;
        t_wr_en   = 1'b0;
        f_rd_addr = fa_addr;
        d_rd_addr = dc_addr;
        p_rd_addr = i_reg;
        p_wr_addr = row_reg;
        p_wr_data = val_reg[IDX_W-1:0];
        b_rd_addr = row_reg;
        t_rd_addr = {i_reg, j_reg};
        t_wr_addr = {i_reg, j_reg};
        unique case (state_reg)
            ST_EXEC: begin
                f_wr_en   = (op_reg == OP_WR_FLOW) && !bad_mat;
                d_wr_en   = (op_reg == OP_WR_DIST) && !bad_mat;
                p_wr_en   = (op_reg == OP_WR_PERM) && !bad_perm;
                p_rd_addr = row_reg;
                t_rd_addr = {row_reg, col_reg};
            end
            ST_CI_CAP:  p_rd_addr = j_reg;
            ST_CJ_CAP: begin
                f_rd_addr = {i_reg, j_reg};
                d_rd_addr = {pi_reg, p_rd_data};
            end
            ST_PR_J:    p_rd_addr = j_reg;
            ST_TB: begin
                f_rd_addr = fb_addr;
                d_rd_addr = dd_addr;
            end
            ST_K_RD:    p_rd_addr = k_reg;
            ST_PAIR_WR: t_wr_en = 1'b1;
            ST_BC_WR:   b_wr_en = 1'b1;
            ST_SW_RD: begin
                t_rd_addr = {r_reg, s_reg};
                p_rd_addr = r_reg;
            end
            ST_SW_CAP1: p_rd_addr = s_reg;
            ST_SW_CAP2: begin
                p_wr_en   = 1'b1;
                p_wr_addr = r_reg;
                p_wr_data = p_rd_data;
            end
            ST_SW_WR2: begin
                p_wr_en   = 1'b1;
                p_wr_addr = s_reg;
                p_wr_data = pi_reg;
            end
            default: begin
            end
        endcase
    end

    qsde_ram #(.WIDTH(ENTRY_W), .DEPTH(MAT_DEPTH)) u_flow (
        .aclk(aclk), .wr_en(f_wr_en), .wr_addr(mat_wr_addr), .wr_data(val_reg),
        .rd_addr(f_rd_addr), .rd_data(f_rd_data)
    );

    qsde_ram #(.WIDTH(ENTRY_W), .DEPTH(MAT_DEPTH)) u_dist (
        .aclk(aclk), .wr_en(d_wr_en), .wr_addr(mat_wr_addr), .wr_data(val_reg),
        .rd_addr(d_rd_addr), .rd_data(d_rd_data)
    );

    qsde_ram #(.WIDTH(IDX_W), .DEPTH(MAX_N)) u_perm (
        .aclk(aclk), .wr_en(p_wr_en), .wr_addr(p_wr_addr), .wr_data(p_wr_data),
        .rd_addr(p_rd_addr), .rd_data(p_rd_data)
    );

    qsde_ram #(.WIDTH(IDX_W), .DEPTH(MAX_N)) u_best (
        .aclk(aclk), .wr_en(b_wr_en), .wr_addr(i_reg), .wr_data(p_rd_data),
        .rd_addr(b_rd_addr), .rd_data(b_rd_data)
    );

    qsde_ram #(.WIDTH(DELTA_W), .DEPTH(MAT_DEPTH)) u_delta (
        .aclk(aclk), .wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_data(acc_reg),
        .rd_addr(t_rd_addr), .rd_data(t_rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            running_reg <= '0;
            lowest_reg  <= '0;
            init_reg    <= 1'b0;
            size_reg    <= CFG_W'(2);
        end else begin
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        op_reg         <= opcode_t'(s_axis_tuser);
                        row_reg        <= s_axis_tdata[IDX_W-1:0];
                        col_reg        <= s_axis_tdata[2*IDX_W-1:IDX_W];
                        val_reg        <= s_axis_tdata[2*IDX_W+ENTRY_W-1:2*IDX_W];
                        res_first_reg  <= '0;
                        res_second_reg <= '0;
                        res_mcost_reg  <= '0;
                        res_moved_reg  <= 1'b0;
                        res_pe_reg     <= '0;
                        res_be_reg     <= '0;
                        res_rej_reg    <= 1'b0;
                        state_reg      <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_FINISH;
                    case (op_reg)
                        OP_WR_FLOW, OP_WR_DIST: begin
                            res_rej_reg <= bad_mat;
                            if (!bad_mat) init_reg <= 1'b0;
                        end
                        OP_WR_PERM: begin
                            res_rej_reg <= bad_perm;
                            if (!bad_perm) init_reg <= 1'b0;
                        end
                        OP_INIT: begin
                            running_reg <= '0;
                            i_reg       <= '0;
                            j_reg       <= '0;
                            state_reg   <= ST_CI_RD;
                        end
                        OP_SWAP: begin
                            res_rej_reg <= bad_swap;
                            if (!bad_swap) begin
                                r_reg          <= row_reg;
                                s_reg          <= col_reg;
                                res_first_reg  <= row_reg;
                                res_second_reg <= col_reg;
                                res_moved_reg  <= 1'b1;
                                state_reg      <= ST_SW_RD;
                            end
                        end
                        OP_STEP: begin
                            res_rej_reg <= !init_reg;
                            if (init_reg) begin
                                ds_best_reg  <= DESCENT_LIMIT;
                                ds_found_reg <= 1'b0;
                                i_reg        <= '0;
                                j_reg        <= IDX_W'(1);
                                state_reg    <= ST_DS_RD;
                            end
                        end
                        OP_READ: begin
                            res_rej_reg <= bad_read;
                            if (!bad_read) state_reg <= ST_RD_WAIT;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_RD_WAIT: begin
                    res_pe_reg    <= p_rd_data;
                    res_be_reg    <= b_rd_data;
                    res_mcost_reg <= read_pair_ok ? t_rd_data : '0;
                    state_reg     <= ST_FINISH;
                end
                // Full cost: one product per matrix cell.
                ST_CI_RD:  state_reg <= ST_CI_CAP;
                ST_CI_CAP: begin
                    pi_reg    <= p_rd_data;
                    state_reg <= ST_CJ_CAP;
                end
                ST_CJ_CAP: state_reg <= ST_CV_MUL;
                ST_CV_MUL: begin
                    prod_reg  <= f_rd_data * d_rd_data;
                    state_reg <= ST_CV_ACC;
                end
                ST_CV_ACC: begin
                    running_reg <= cost_sum;
                    state_reg   <= ST_CI_RD;
                    if (j_last) begin
                        j_reg <= '0;
                        i_reg <= i_reg + IDX_W'(1);
                        if (({1'b0, i_reg} + N_W'(1)) == n_eff) begin
                            lowest_reg <= cost_sum;
                            init_reg   <= 1'b1;
                            i_reg      <= '0;
                            j_reg      <= IDX_W'(1);
                            state_reg  <= ST_PR_I;
                        end
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                // Full delta of pair (i, j).
                ST_PR_I: state_reg <= ST_PR_J;
                ST_PR_J: begin
                    pi_reg    <= p_rd_data;
                    state_reg <= ST_PR_JC;
                end
                ST_PR_JC: begin
                    pj_reg    <= p_rd_data;
                    acc_reg   <= '0;
                    sel_reg   <= TERM_DIAG;
                    state_reg <= ST_TA;
                end
                ST_TA: state_reg <= ST_TB;
                ST_TB: begin
                    fa_reg    <= f_rd_data;
                    dc_reg    <= d_rd_data;
                    state_reg <= ST_TC;
                end
                ST_TC: begin
                    da_reg    <= $signed({1'b0, fa_reg}) - $signed({1'b0, f_rd_data});
                    db_reg    <= $signed({1'b0, dc_reg}) - $signed({1'b0, d_rd_data});
                    state_reg <= ST_TD;
                end
                ST_TD: begin
                    acc_reg <= acc_reg + DELTA_W'(term_prod);
                    unique case (sel_reg)
                        TERM_DIAG: begin
                            sel_reg   <= TERM_CROSS;
                            state_reg <= ST_TA;
                        end
                        TERM_CROSS: begin
                            k_reg     <= '0;
                            state_reg <= ST_K_RD;
                        end
                        TERM_COL: begin
                            sel_reg   <= TERM_ROW;
                            state_reg <= ST_TA;
                        end
                        TERM_ROW: begin
                            k_reg     <= k_reg + IDX_W'(1);
                            state_reg <= k_last ? ST_PAIR_WR : ST_K_RD;
                        end
                        default: state_reg <= ST_PAIR_WR;
                    endcase
                end
                ST_K_RD: begin
                    if (k_skip) begin
                        k_reg     <= k_reg + IDX_W'(1);
                        state_reg <= k_last ? ST_PAIR_WR : ST_K_RD;
                    end else begin
                        state_reg <= ST_K_CAP;
                    end
                end
                ST_K_CAP: begin
                    pk_reg    <= p_rd_data;
                    sel_reg   <= TERM_COL;
                    state_reg <= ST_TA;
                end
                ST_PAIR_WR: begin
                    if (pair_last) begin
                        i_reg <= '0;
                        if (op_reg == OP_INIT) begin
                            state_reg <= ST_BC_RD;
                        end else if (running_reg < lowest_reg) begin
                            lowest_reg <= running_reg;
                            state_reg  <= ST_BC_RD;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end else begin
                        if (j_last) begin
                            i_reg <= i_reg + IDX_W'(1);
                            j_reg <= i_reg + IDX_W'(2);
                        end else begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                        state_reg <= ST_PR_I;
                    end
                end
                // Copy of the assignment into the best store.
                ST_BC_RD: state_reg <= ST_BC_WR;
                ST_BC_WR: begin
                    i_reg     <= i_reg + IDX_W'(1);
                    state_reg <= (({1'b0, i_reg} + N_W'(1)) == n_eff) ? ST_FINISH : ST_BC_RD;
                end
                // Exchange of positions r and s, then a full table pass.
                ST_SW_RD: state_reg <= ST_SW_CAP1;
                ST_SW_CAP1: begin
                    res_mcost_reg <= t_rd_data;
                    pi_reg        <= p_rd_data;
                    state_reg     <= ST_SW_CAP2;
                end
                ST_SW_CAP2: begin
                    running_reg <= running_reg + res_mcost_reg[COST_W-1:0];
                    state_reg   <= ST_SW_WR2;
                end
                ST_SW_WR2: begin
                    i_reg     <= '0;
                    j_reg     <= IDX_W'(1);
                    state_reg <= ST_PR_I;
                end
                // Descent scan: first strict minimum in pair order.
                ST_DS_RD: state_reg <= ST_DS_CAP;
                ST_DS_CAP: begin
                    if ($signed(t_rd_data) < ds_best_reg) begin
                        ds_best_reg  <= $signed(t_rd_data);
                        ds_bi_reg    <= i_reg;
                        ds_bj_reg    <= j_reg;
                        ds_found_reg <= 1'b1;
                    end
                    if (pair_last) begin
                        state_reg <= ST_DS_END;
                    end else begin
                        if (j_last) begin
                            i_reg <= i_reg + IDX_W'(1);
                            j_reg <= i_reg + IDX_W'(2);
                        end else begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                        state_reg <= ST_DS_RD;
                    end
                end
                ST_DS_END: begin
                    state_reg <= ST_FINISH;
                    if (ds_found_reg) begin
                        res_first_reg  <= ds_bi_reg;
                        res_second_reg <= ds_bj_reg;
                        res_mcost_reg  <= ds_best_reg;
                        if (ds_best_reg[DELTA_W-1]) begin
                            r_reg         <= ds_bi_reg;
                            s_reg         <= ds_bj_reg;
                            res_moved_reg <= 1'b1;
                            state_reg     <= ST_SW_RD;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {res_rej_reg, res_be_reg, res_pe_reg, res_moved_reg,
                                        res_mcost_reg, res_second_reg, res_first_reg,
                                        lowest_reg, running_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
                init_reg <= 1'b0;
            end
        end
    end

endmodule

### src/qsde_checker.sv
// Port-level checker for the swap delta engine, bound to the top level.
// Depends on qsde_pkg.
module qsde_checker
    import qsde_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // A beat held back by the sink keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A refused command reports no pair, no delta, no move and no store entries.
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[159] |->
            m_axis_tdata[146:88] == '0 && m_axis_tdata[158:147] == '0)
        else $error("rejected beat carries move data");

    // An applied swap always names an ordered pair.
    a_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[146] |-> m_axis_tdata[93:88] < m_axis_tdata[99:94])
        else $error("applied swap with unordered positions");

endmodule

bind qap_swap_delta_engine qsde_checker u_qsde_checker (.*);
